// File: rtl/aps_pkg.sv
// Shared types and codes for the aging priority task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package aps_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ADMIT     = 3'd1,
    CMD_YIELD     = 3'd2,
    CMD_SLEEP     = 3'd3,
    CMD_SUSPEND   = 3'd4,
    CMD_RESUME    = 3'd5,
    CMD_TERMINATE = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    SLOT_FREE      = 3'd0,
    SLOT_READY     = 3'd1,
    SLOT_RUNNING   = 3'd2,
    SLOT_SLEEPING  = 3'd3,
    SLOT_SUSPENDED = 3'd4
  } slot_state_t;

  localparam logic [1:0] RES_DONE    = 2'd0;
  localparam logic [1:0] RES_IGNORED = 2'd1;
  localparam logic [1:0] RES_REFUSED = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       admit;
    logic       queue_slot;
    logic       queue_cur;
    logic       sleep_cur;
    logic       idx_clear;
    logic       drop_r_step;
    logic       drop_s_step;
    logic       set_susp;
    logic       set_free;
    logic       wake_step;
    logic       pick_step;
    logic       commit;
    logic       result_wr;
    logic [1:0] res_status;
    logic       res_sw;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t        cmd;
    logic        en;
    logic        slot_ok;
    slot_state_t slot_st;
    logic        run_ok;
    logic        cur_is_slot;
    logic        rlen_zero;
    logic        slen_full;
    logic        idx_lt_rlen;
    logic        idx_lt_slen;
    logic        drop_r_hit;
    logic        out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/aps_if.sv
// Handshake channels for scheduler command and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface aps_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [2:0]  task_slot;
  logic [7:0]  priority_req;
  logic [30:0] sleep_ms;
  logic [31:0] now_ms;
  modport source(output valid, cmd, task_slot, priority_req, sleep_ms, now_ms, input ready);
  modport sink(input valid, cmd, task_slot, priority_req, sleep_ms, now_ms, output ready);
endinterface

interface aps_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       switched;
  logic       running_valid;
  logic [2:0] running_slot;
  logic [3:0] ready_count;
  modport source(output valid, status, switched, running_valid, running_slot, ready_count,
                 input ready);
  modport sink(input valid, status, switched, running_valid, running_slot, ready_count,
               output ready);
endinterface
`default_nettype wire

// File: rtl/aging_priority_task_scheduler.sv
// Top level of the aging priority task scheduler.
// A command that needs no scan passes through accept, decode and result write.
// A switch step adds a wake scan over the sleepers, a requeue step and a pick scan over the ready list.
// Suspend/terminate add removal scans of the ready list and of the sleeper list.
// One beat at a time: the next beat is taken once the result is in the output register.
// Synchronous active-low reset: all slots free, lists empty, no task running, enable 1.
`timescale 1ns / 1ps
`default_nettype none
module aging_priority_task_scheduler #(
  parameter int TASK_SLOTS = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire          cfg_wdata,
  aps_in_if.sink       in_bus,
  aps_out_if.source    out_bus
);
  import aps_pkg::*;

  dp_cmd_t  dp_cmd;   // sequencer commands
  dp_stat_t dp_stat;  // datapath flags

  // Sequencer: owns the input handshake and walks the list scans.
  aps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  // Datapath: slot tables, ready and sleeper lists, result register.
  aps_datapath #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_bus.cmd),
    .in_task_slot      (in_bus.task_slot),
    .in_priority_req   (in_bus.priority_req),
    .in_sleep_ms       (in_bus.sleep_ms),
    .in_now_ms         (in_bus.now_ms),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .out_valid         (out_bus.valid),
    .out_ready         (out_bus.ready),
    .out_status        (out_bus.status),
    .out_switched      (out_bus.switched),
    .out_running_valid (out_bus.running_valid),
    .out_running_slot  (out_bus.running_slot),
    .out_ready_count   (out_bus.ready_count)
  );

  // A switch always leaves a task running and reports success.
  a_switch_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.switched |-> out_bus.running_valid
                                          && out_bus.status == RES_DONE)
    else $error("switch beat without a running task");

  // Slot field is zeroed when nothing runs.
  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.running_valid |-> out_bus.running_slot == 3'd0)
    else $error("running_slot set while idle");

  // Only done beats may change the ready list via a switch; refused beats never switch.
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status == RES_REFUSED |-> !out_bus.switched)
    else $error("refused beat switched");

  // Results are written only while the sequencer is busy, so no beat is taken then.
  a_no_accept_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.result_wr |-> !in_bus.ready)
    else $error("input taken during result write");

endmodule
`default_nettype wire

// File: rtl/aps_datapath.sv
// Scheduler datapath: slot tables, ready/sleep lists, scan index, result register.
`timescale 1ns / 1ps
`default_nettype none
module aps_datapath #(
  parameter int TASK_SLOTS = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire                 cfg_wdata,
  input  wire [2:0]           in_cmd,
  input  wire [2:0]           in_task_slot,
  input  wire [7:0]           in_priority_req,
  input  wire [30:0]          in_sleep_ms,
  input  wire [31:0]          in_now_ms,
  input  aps_pkg::dp_cmd_t    cmd_i,
  output aps_pkg::dp_stat_t   stat_o,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [1:0]          out_status,
  output logic                out_switched,
  output logic                out_running_valid,
  output logic [2:0]          out_running_slot,
  output logic [3:0]          out_ready_count
);
  import aps_pkg::*;

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int LW = $clog2(TASK_SLOTS + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(TASK_SLOTS);
  localparam logic [LW-1:0] LEN_ONE = LW'(1);

  slot_state_t     slot_status_r [TASK_SLOTS];
  logic [7:0]      slot_prio_r   [TASK_SLOTS];
  logic [7:0]      slot_wait_r   [TASK_SLOTS];
  logic [31:0]     slot_wake_r   [TASK_SLOTS];
  logic [SW-1:0]   rlist_r       [TASK_SLOTS];
  logic [SW-1:0]   slist_r       [TASK_SLOTS];
  logic [LW-1:0]   rlen_r, slen_r, idx_r;
  logic            cv_r;
  logic [SW-1:0]   cur_r;
  logic            en_r;

  cmd_t            cmd_in_r;
  logic [2:0]      slot_in_r;
  logic [7:0]      prio_in_r;
  logic [30:0]     sms_in_r;
  logic [31:0]     now_in_r;

  logic [SW-1:0]   best_r, bpos_r;
  logic [8:0]      bscore_r;
  logic            best_v_r;

  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic            out_sw_r;
  logic            out_rv_r;
  logic [2:0]      out_rs_r;
  logic [3:0]      out_rc_r;

  logic [SW-1:0]   slot_idx, idx_i, rlast, slast, ws, ps;
  logic [LW-1:0]   rlen_m1, slen_m1;
  logic            run_ok, idx_lt_rlen, idx_lt_slen, r_hit, s_hit, due;
  logic [31:0]     wdiff;
  logic [8:0]      pscore;

  assign slot_idx    = SW'(slot_in_r);
  assign idx_i       = idx_r[SW-1:0];
  assign rlen_m1     = rlen_r - LEN_ONE;
  assign slen_m1     = slen_r - LEN_ONE;
  assign rlast       = rlen_m1[SW-1:0];
  assign slast       = slen_m1[SW-1:0];
  assign run_ok      = cv_r && (slot_status_r[cur_r] == SLOT_RUNNING);
  assign idx_lt_rlen = idx_r < rlen_r;
  assign idx_lt_slen = idx_r < slen_r;
  assign r_hit       = idx_lt_rlen && (rlist_r[idx_i] == slot_idx);
  assign s_hit       = slist_r[idx_i] == slot_idx;
  assign ws          = slist_r[idx_i];
  assign wdiff       = now_in_r - slot_wake_r[ws];
  assign due         = !wdiff[31];
  assign ps          = rlist_r[idx_i];
  assign pscore      = {1'b0, slot_prio_r[ps]} + {1'b0, slot_wait_r[ps]};

  always_comb begin
    stat_o             = '0;
    stat_o.cmd         = cmd_in_r;
    stat_o.en          = en_r;
    stat_o.slot_ok     = 32'(slot_in_r) < TASK_SLOTS;
    stat_o.slot_st     = slot_status_r[slot_idx];
    stat_o.run_ok      = run_ok;
    stat_o.cur_is_slot = cv_r && (cur_r == slot_idx);
    stat_o.rlen_zero   = rlen_r == '0;
    stat_o.slen_full   = slen_r >= LEN_MAX;
    stat_o.idx_lt_rlen = idx_lt_rlen;
    stat_o.idx_lt_slen = idx_lt_slen;
    stat_o.drop_r_hit  = r_hit;
    stat_o.out_busy    = out_valid_r && !out_ready;
  end

  // input capture and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
    end else if (cfg_we) begin
      en_r <= cfg_wdata;
    end
    if (cmd_i.load) begin
      cmd_in_r  <= cmd_t'(in_cmd);
      slot_in_r <= in_task_slot;
      prio_in_r <= in_priority_req;
      sms_in_r  <= in_sleep_ms;
      now_in_r  <= in_now_ms;
    end
  end

  // slot tables and lists; list membership tracks the READY status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        slot_status_r[k] <= SLOT_FREE;
        slot_wait_r[k]   <= '0;
      end
      rlen_r   <= '0;
      slen_r   <= '0;
      idx_r    <= '0;
      cv_r     <= 1'b0;
      cur_r    <= '0;
      best_v_r <= 1'b0;
    end else begin
      if (cmd_i.idx_clear) begin
        idx_r    <= '0;
        best_v_r <= 1'b0;
      end
      if (cmd_i.admit) begin
        slot_prio_r[slot_idx] <= prio_in_r;
        slot_wait_r[slot_idx] <= '0;
      end
      if ((cmd_i.admit || cmd_i.queue_slot) && slot_status_r[slot_idx] != SLOT_READY
          && rlen_r < LEN_MAX) begin
        slot_status_r[slot_idx]    <= SLOT_READY;
        rlist_r[rlen_r[SW-1:0]]    <= slot_idx;
        rlen_r                     <= rlen_r + LEN_ONE;
      end
      if (cmd_i.queue_cur && slot_status_r[cur_r] != SLOT_READY && rlen_r < LEN_MAX) begin
        slot_status_r[cur_r]    <= SLOT_READY;
        rlist_r[rlen_r[SW-1:0]] <= cur_r;
        rlen_r                  <= rlen_r + LEN_ONE;
      end
      if (cmd_i.sleep_cur) begin
        slot_status_r[cur_r]    <= SLOT_SLEEPING;
        slot_wake_r[cur_r]      <= now_in_r + {1'b0, sms_in_r};
        slist_r[slen_r[SW-1:0]] <= cur_r;
        slen_r                  <= slen_r + LEN_ONE;
      end
      if (cmd_i.drop_r_step) begin
        if (r_hit) begin
          rlist_r[idx_i] <= rlist_r[rlast];
          rlen_r         <= rlen_m1;
        end else begin
          idx_r <= idx_r + LEN_ONE;
        end
      end
      if (cmd_i.drop_s_step) begin
        if (s_hit) begin
          slist_r[idx_i] <= slist_r[slast];
          slen_r         <= slen_m1;
        end else begin
          idx_r <= idx_r + LEN_ONE;
        end
      end
      if (cmd_i.set_susp) begin
        slot_status_r[slot_idx] <= SLOT_SUSPENDED;
      end
      if (cmd_i.set_free) begin
        slot_status_r[slot_idx] <= SLOT_FREE;
        slot_wait_r[slot_idx]   <= '0;
        if (cv_r && cur_r == slot_idx) begin
          cv_r <= 1'b0;
        end
      end
      if (cmd_i.wake_step) begin
        if (due) begin
          if (slot_status_r[ws] != SLOT_READY && rlen_r < LEN_MAX) begin
            slot_status_r[ws]       <= SLOT_READY;
            rlist_r[rlen_r[SW-1:0]] <= ws;
            rlen_r                  <= rlen_r + LEN_ONE;
          end
          slist_r[idx_i] <= slist_r[slast];
          slen_r         <= slen_m1;
        end else begin
          idx_r <= idx_r + LEN_ONE;
        end
      end
      if (cmd_i.pick_step) begin
        if (!best_v_r || pscore > bscore_r) begin
          best_v_r <= 1'b1;
          bscore_r <= pscore;
          best_r   <= ps;
          bpos_r   <= idx_i;
        end
        if (slot_wait_r[ps] != 8'hFF) begin
          slot_wait_r[ps] <= slot_wait_r[ps] + 8'd1;
        end
        idx_r <= idx_r + LEN_ONE;
      end
      if (cmd_i.commit) begin
        slot_wait_r[best_r]   <= '0;
        rlist_r[bpos_r]       <= rlist_r[rlast];
        rlen_r                <= rlen_m1;
        slot_status_r[best_r] <= SLOT_RUNNING;
        cur_r                 <= best_r;
        cv_r                  <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.result_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd_i.result_wr) begin
      out_status_r <= cmd_i.res_status;
      out_sw_r     <= cmd_i.res_sw;
      out_rv_r     <= run_ok;
      out_rs_r     <= run_ok ? 3'(cur_r) : 3'd0;
      out_rc_r     <= 4'(rlen_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_switched      = out_sw_r;
  assign out_running_valid = out_rv_r;
  assign out_running_slot  = out_rs_r;
  assign out_ready_count   = out_rc_r;

endmodule
`default_nettype wire

// File: rtl/aps_ctrl.sv
// Scheduler sequencer: decodes a command beat and steps the datapath scans.
`timescale 1ns / 1ps
`default_nettype none
module aps_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  aps_pkg::dp_stat_t  stat_i,
  output aps_pkg::dp_cmd_t   cmd_o
);
  import aps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_DROP_R, S_DROP_S, S_WAKE, S_REQUEUE, S_PICK, S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic       res_sw_r, res_sw_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd_o          = '0;
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_sw_nxt     = res_sw_r;
    cmd_o.res_status = res_status_r;
    cmd_o.res_sw     = res_sw_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load     = 1'b1;
          res_status_nxt = RES_IGNORED;
          res_sw_nxt     = 1'b0;
          state_nxt      = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        case (stat_i.cmd)
          CMD_TICK: begin
            if (stat_i.en) begin
              cmd_o.idx_clear = 1'b1;
              res_status_nxt  = RES_DONE;
              state_nxt       = S_WAKE;
            end
          end
          CMD_ADMIT: begin
            if (stat_i.slot_ok) begin
              if (stat_i.slot_st != SLOT_FREE) begin
                res_status_nxt = RES_REFUSED;
              end else begin
                cmd_o.admit    = 1'b1;
                res_status_nxt = RES_DONE;
              end
            end
          end
          CMD_YIELD: begin
            if (stat_i.run_ok) begin
              cmd_o.queue_cur = 1'b1;
              cmd_o.idx_clear = 1'b1;
              res_status_nxt  = RES_DONE;
              state_nxt       = S_WAKE;
            end
          end
          CMD_SLEEP: begin
            if (stat_i.run_ok && !stat_i.slen_full) begin
              cmd_o.sleep_cur = 1'b1;
              cmd_o.idx_clear = 1'b1;
              res_status_nxt  = RES_DONE;
              state_nxt       = S_WAKE;
            end
          end
          CMD_SUSPEND: begin
            if (stat_i.slot_ok && stat_i.slot_st != SLOT_FREE
                && stat_i.slot_st != SLOT_SUSPENDED) begin
              cmd_o.idx_clear = 1'b1;
              res_status_nxt  = RES_DONE;
              state_nxt       = S_DROP_R;
            end
          end
          CMD_RESUME: begin
            if (stat_i.slot_ok && stat_i.slot_st == SLOT_SUSPENDED) begin
              cmd_o.queue_slot = 1'b1;
              res_status_nxt   = RES_DONE;
            end
          end
          CMD_TERMINATE: begin
            if (stat_i.slot_ok && stat_i.slot_st != SLOT_FREE) begin
              cmd_o.idx_clear = 1'b1;
              res_status_nxt  = RES_DONE;
              state_nxt       = S_DROP_R;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_DROP_R: begin
        if (stat_i.idx_lt_rlen) begin
          cmd_o.drop_r_step = 1'b1;
        end
        if (!stat_i.idx_lt_rlen || stat_i.drop_r_hit) begin
          cmd_o.idx_clear = 1'b1;
          state_nxt       = S_DROP_S;
        end
      end
      S_DROP_S: begin
        if (stat_i.idx_lt_slen) begin
          cmd_o.drop_s_step = 1'b1;
        end else if (stat_i.cmd == CMD_SUSPEND) begin
          cmd_o.set_susp = 1'b1;
          if (stat_i.cur_is_slot) begin
            cmd_o.idx_clear = 1'b1;
            state_nxt       = S_WAKE;
          end else begin
            state_nxt = S_FINISH;
          end
        end else begin
          cmd_o.set_free = 1'b1;
          state_nxt      = S_FINISH;
        end
      end
      S_WAKE: begin
        if (stat_i.idx_lt_slen) begin
          cmd_o.wake_step = 1'b1;
        end else begin
          state_nxt = S_REQUEUE;
        end
      end
      S_REQUEUE: begin
        cmd_o.idx_clear = 1'b1;
        if (stat_i.rlen_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd_o.queue_cur = stat_i.run_ok;
          state_nxt       = S_PICK;
        end
      end
      S_PICK: begin
        if (stat_i.idx_lt_rlen) begin
          cmd_o.pick_step = 1'b1;
        end else begin
          cmd_o.commit = 1'b1;
          res_sw_nxt   = 1'b1;
          state_nxt    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.result_wr = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= RES_IGNORED;
      res_sw_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_sw_r     <= res_sw_nxt;
    end
  end

endmodule
`default_nettype wire
